// ----- rtl/core/jsu_pkg.sv -----
// Shared types, character constants and helpers for the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

	localparam int VAL_W = 16;
	localparam int ACC_W = 12;

	// Characters of interest (ASCII range, widened where compared)
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;

	typedef enum logic [1:0] {
		PH_SEEK = 2'd0,
		PH_BODY = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_UNIT = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE     = 3'd0,
		E_NO_QUOTE = 3'd1,
		E_CONTROL  = 3'd2,
		E_ESCAPE   = 3'd3,
		E_HEX      = 3'd4,
		E_UNTERM   = 3'd5
	} err_t;

	// Parser state carried from one beat to the next
	typedef struct packed {
		phase_t             phase;
		logic [1:0]         hex_count;
		logic [ACC_W-1:0]   hex_accum;
	} jsu_state_t;

	// One result beat, valid flags whether the beat produces one
	typedef struct packed {
		logic               valid;
		kind_t              kind;
		logic [VAL_W-1:0]   value;
		err_t               error_code;
	} jsu_result_t;

	localparam jsu_state_t STATE_RESET = '{phase: PH_SEEK, hex_count: 2'd0, hex_accum: '0};

	function automatic jsu_result_t mk_result(kind_t k, logic [VAL_W-1:0] v, err_t e);
		jsu_result_t r;
		r.valid      = 1'b1;
		r.kind       = k;
		r.value      = v;
		r.error_code = e;
		return r;
	endfunction

	// Hex digit decode on the low byte; ok is low for anything else
	function automatic logic [4:0] hex_nibble(logic [7:0] c, logic hi_zero);
		logic [4:0] r;
		r = 5'd0;
		if (hi_zero) begin
			if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
			else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
			else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/jsu_if.sv -----
// Valid/ready channel interfaces for code units in and results out.
`timescale 1ns / 1ps
`default_nettype none

interface jsu_in_if #(parameter int UNIT_WIDTH = 16);
	logic                  valid;
	logic                  ready;
	logic [UNIT_WIDTH-1:0] unit;
	logic                  end_of_text;

	modport source (output valid, output unit, output end_of_text, input ready);
	modport sink   (input valid, input unit, input end_of_text, output ready);
endinterface

interface jsu_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] value;
	logic [2:0]  error_code;

	modport source (output valid, output kind, output value, output error_code, input ready);
	modport sink   (input valid, input kind, input value, input error_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/jsu_step.sv -----
// Next-state and result logic for one code unit.
`timescale 1ns / 1ps
`default_nettype none

module jsu_step
	import jsu_pkg::*;
#(
	parameter int UNIT_WIDTH = 16
) (
	input  jsu_state_t            st,
	input  logic [UNIT_WIDTH-1:0] unit,
	input  logic                  last,
	output jsu_state_t            nxt,
	output jsu_result_t           res
);

	logic [VAL_W-1:0] unit_val;
	logic [4:0]       nib;
	logic [7:0]       low_byte;
	logic             hi_zero;
	logic             is_ws;
	logic             esc_hit;
	logic [VAL_W-1:0] esc_val;

	// Widen or trim the unit to the 16-bit result value
	generate
		if (UNIT_WIDTH >= VAL_W) begin : g_trim
			assign unit_val = unit[VAL_W-1:0];
		end else begin : g_ext
			assign unit_val = {{(VAL_W-UNIT_WIDTH){1'b0}}, unit};
		end
		if (UNIT_WIDTH > 8) begin : g_hi
			assign hi_zero = (unit[UNIT_WIDTH-1:8] == '0);
		end else begin : g_nohi
			assign hi_zero = 1'b1;
		end
	endgenerate

	assign low_byte = unit[7:0];
	assign nib      = hex_nibble(low_byte, hi_zero);
	assign is_ws    = (unit == UNIT_WIDTH'(CH_SPACE)) || (unit == UNIT_WIDTH'(CH_TAB)) ||
	                  (unit == UNIT_WIDTH'(CH_CR)) || (unit == UNIT_WIDTH'(CH_LF));

	// Single-character escape decode
	always_comb begin
		esc_hit = 1'b1;
		esc_val = '0;
		priority if (unit == UNIT_WIDTH'(CH_QUOTE))  esc_val = VAL_W'(CH_QUOTE);
		else if (unit == UNIT_WIDTH'(CH_BSLASH))     esc_val = VAL_W'(CH_BSLASH);
		else if (unit == UNIT_WIDTH'(CH_SLASH))      esc_val = VAL_W'(CH_SLASH);
		else if (unit == UNIT_WIDTH'(CH_B))          esc_val = VAL_W'(CH_BS);
		else if (unit == UNIT_WIDTH'(CH_F))          esc_val = VAL_W'(CH_FF);
		else if (unit == UNIT_WIDTH'(CH_N))          esc_val = VAL_W'(CH_LF);
		else if (unit == UNIT_WIDTH'(CH_R))          esc_val = VAL_W'(CH_CR);
		else if (unit == UNIT_WIDTH'(CH_T))          esc_val = VAL_W'(CH_TAB);
		else                                         esc_hit = 1'b0;
	end

	// Phase transitions and result selection
	always_comb begin
		nxt = st;
		res = '{valid: 1'b0, kind: KIND_UNIT, value: '0, error_code: E_NONE};
		unique case (st.phase)
			PH_SEEK: begin
				if (is_ws) begin
					if (last) res = mk_result(KIND_ERR, '0, E_NO_QUOTE);
				end else if (unit != UNIT_WIDTH'(CH_QUOTE)) begin
					res = mk_result(KIND_ERR, '0, E_NO_QUOTE);
				end else if (last) begin
					res = mk_result(KIND_ERR, '0, E_UNTERM);
				end else begin
					nxt.phase = PH_BODY;
				end
			end
			PH_BODY: begin
				if (unit == UNIT_WIDTH'(CH_QUOTE)) begin
					res = mk_result(KIND_DONE, '0, E_NONE);
				end else if (unit == UNIT_WIDTH'(CH_BSLASH)) begin
					if (last) res = mk_result(KIND_ERR, '0, E_UNTERM);
					else nxt.phase = PH_ESC;
				end else if (unit < UNIT_WIDTH'(CH_SPACE)) begin
					res = mk_result(KIND_ERR, '0, E_CONTROL);
				end else if (last) begin
					res = mk_result(KIND_ERR, '0, E_UNTERM);
				end else begin
					res = mk_result(KIND_UNIT, unit_val, E_NONE);
				end
			end
			PH_ESC: begin
				if (unit == UNIT_WIDTH'(CH_U)) begin
					if (last) begin
						res = mk_result(KIND_ERR, '0, E_UNTERM);
					end else begin
						nxt.phase     = PH_HEX;
						nxt.hex_count = 2'd0;
						nxt.hex_accum = '0;
					end
				end else if (!esc_hit) begin
					res = mk_result(KIND_ERR, '0, E_ESCAPE);
				end else if (last) begin
					res = mk_result(KIND_ERR, '0, E_UNTERM);
				end else begin
					nxt.phase = PH_BODY;
					res = mk_result(KIND_UNIT, esc_val, E_NONE);
				end
			end
			PH_HEX: begin
				if (st.hex_count != 2'd3) begin
					if (last) begin
						res = mk_result(KIND_ERR, '0, E_UNTERM);
					end else if (!nib[4]) begin
						res = mk_result(KIND_ERR, '0, E_HEX);
					end else begin
						nxt.hex_accum = {st.hex_accum[ACC_W-5:0], nib[3:0]};
						nxt.hex_count = st.hex_count + 2'd1;
					end
				end else if (!nib[4]) begin
					res = mk_result(KIND_ERR, '0, E_HEX);
				end else if (last) begin
					res = mk_result(KIND_ERR, '0, E_UNTERM);
				end else begin
					nxt.phase     = PH_BODY;
					nxt.hex_count = 2'd0;
					nxt.hex_accum = '0;
					res = mk_result(KIND_UNIT, {st.hex_accum, nib[3:0]}, E_NONE);
				end
			end
			default: nxt = STATE_RESET;
		endcase
		// Done or error drops back to seeking the next string
		if (res.valid && res.kind != KIND_UNIT) nxt = STATE_RESET;
	end

endmodule

`default_nettype wire

// ----- rtl/core/jsu_out_reg.sv -----
// Result register driving the output channel.
`timescale 1ns / 1ps
`default_nettype none

module jsu_out_reg
	import jsu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  jsu_result_t       res,
	output logic              can_load,
	jsu_out_if.source         out
);

	logic             valid_q;
	kind_t            kind_q;
	logic [VAL_W-1:0] value_q;
	err_t             err_q;

	// Register is free when empty or its beat leaves this cycle
	assign can_load = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load && res.valid;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (can_load && load && res.valid) begin
			kind_q  <= res.kind;
			value_q <= res.value;
			err_q   <= res.error_code;
		end
	end

	assign out.valid      = valid_q;
	assign out.kind       = kind_q;
	assign out.value      = value_q;
	assign out.error_code = err_q;

endmodule

`default_nettype wire

// ----- rtl/core/json_string_unescape.sv -----
// Top level of the JSON string unescaper: input stage, parser state, result register.
//
//   channel  dir  payload                          handshake
//   in       in   unit[UNIT_WIDTH], end_of_text    valid/ready
//   out      out  kind[2], value[16], error_code[3] valid/ready
//
// One code unit per cycle sustained while the output is not stalled; a result is
// offered once its unit's beat has passed the input register and then the result register.
// arst_n clears the stage valids and returns the parser to seeking a quote.
// A stalled output holds the result register and then the input register;
// while a result waits, units that give no result are held as well.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape
	import jsu_pkg::*;
#(
	parameter int UNIT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	jsu_in_if.sink     in,
	jsu_out_if.source  out
);

	logic                  valid_s1;
	logic [UNIT_WIDTH-1:0] unit_s1;
	logic                  last_s1;
	jsu_state_t            state_q;
	jsu_state_t            state_nxt;
	jsu_result_t           res;
	logic                  can_load;
	logic                  advance;

	assign advance  = valid_s1 && can_load;
	assign in.ready = !valid_s1 || can_load;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			unit_s1 <= in.unit;
			last_s1 <= in.end_of_text;
		end
	end

	// Parser state advances once per consumed unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	jsu_step #(.UNIT_WIDTH(UNIT_WIDTH)) u_step (
		.st   (state_q),
		.unit (unit_s1),
		.last (last_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	jsu_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.can_load (can_load),
		.out      (out)
	);

endmodule

`default_nettype wire
